[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the checker file svs_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

[hw/rtl/svs_pkg.sv]
// ----------------------------------------------------------------------------
// svs_pkg
// types and constants of the sphere voxel select block
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int unsigned NumStages = 7;
  localparam int unsigned MaxDim    = 256;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PosW    = 32;
  localparam int unsigned CellW   = 31;
  localparam int unsigned CoordW  = 8;
  localparam int unsigned DimW    = 9;
  localparam int unsigned RadW    = 31;
  localparam int unsigned IdxW    = 24;

  // (2*coord + 1) * cell
  localparam int unsigned ProdW   = CoordW + 1 + CellW;
  // origin + prod/2 before saturation
  localparam int unsigned PSumW   = ProdW + 1;
  // twice the offset from the sphere center
  localparam int unsigned DiffW   = ProdW + 2;
  localparam int unsigned LoW     = 32;
  localparam int unsigned HiW     = DiffW - LoW;
  localparam int unsigned SqW     = 2 * DiffW;
  localparam int unsigned SumSqW  = SqW + 2;
  localparam int unsigned R2W     = 2 * RadW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 4'd0,
    CFG_ORIGIN_Y = 4'd1,
    CFG_ORIGIN_Z = 4'd2,
    CFG_CELL_X   = 4'd3,
    CFG_CELL_Y   = 4'd4,
    CFG_CELL_Z   = 4'd5,
    CFG_DIM_X    = 4'd6,
    CFG_DIM_Y    = 4'd7
  } svs_cfg_idx_e;

  // one load enable per pipeline register stage
  typedef logic [NumStages-1:0] svs_stage_en_t;

  typedef struct packed {
    logic signed [PosW-1:0]  origin;
    logic        [CellW-1:0] cell_size;
  } svs_axis_cfg_t;

  typedef struct packed {
    logic        [CoordW-1:0] voxel_x;
    logic        [CoordW-1:0] voxel_y;
    logic        [CoordW-1:0] voxel_z;
    logic                     solid;
    logic signed [PosW-1:0]   center_x;
    logic signed [PosW-1:0]   center_y;
    logic signed [PosW-1:0]   center_z;
    logic        [RadW-1:0]   radius;
  } svs_in_t;

  typedef struct packed {
    logic                   selected;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic        [IdxW-1:0] voxel_index;
  } svs_out_t;

endpackage

[hw/rtl/svs_axis.sv]
// ----------------------------------------------------------------------------
// svs_axis
// one axis: voxel center position and squared offset to the sphere center
// ----------------------------------------------------------------------------
module svs_axis (
  input  logic                                clk_i,
  input  svs_pkg::svs_stage_en_t              en_i,
  input  svs_pkg::svs_axis_cfg_t              cfg_i,
  input  logic        [svs_pkg::CoordW-1:0]   coord_i,
  input  logic signed [svs_pkg::PosW-1:0]     center_i,
  output logic signed [svs_pkg::PosW-1:0]     pos_o,
  output logic        [svs_pkg::SqW-1:0]      sq_o
);

  localparam int unsigned ProdW = svs_pkg::ProdW;
  localparam int unsigned PSumW = svs_pkg::PSumW;
  localparam int unsigned DiffW = svs_pkg::DiffW;
  localparam int unsigned PosW  = svs_pkg::PosW;
  localparam int unsigned LoW   = svs_pkg::LoW;
  localparam int unsigned HiW   = svs_pkg::HiW;
  localparam int unsigned SqW   = svs_pkg::SqW;

  logic [ProdW-1:0]         prod_d, prod_q;
  logic signed [PosW-1:0]   ctr_q;
  logic [DiffW-1:0]         org_ext, ctr_ext, diff_d, diff_q;
  logic [PSumW-1:0]         psum;
  logic [PSumW-PosW:0]      psum_top;
  logic [PosW-1:0]          pos_d;
  logic [PosW-1:0]          pos2_q, pos3_q, pos4_q, pos5_q;
  logic [DiffW-1:0]         mag_d, mag_q;
  logic [LoW-1:0]           lo;
  logic [HiW-1:0]           hi;
  logic [2*LoW-1:0]         ll_d, ll_q;
  logic [HiW+LoW-1:0]       hl_d, hl_q;
  logic [2*HiW-1:0]         hh_d, hh_q;
  logic [SqW-1:0]           sq_d, sq_q;

  // stage 1: odd multiple of the cell size
  assign prod_d = ProdW'({coord_i, 1'b1}) * ProdW'(cfg_i.cell_size);

  // stage 2: twice the offset, and the saturated center position
  assign org_ext = {{(DiffW-PosW){cfg_i.origin[PosW-1]}}, cfg_i.origin};
  assign ctr_ext = {{(DiffW-PosW){ctr_q[PosW-1]}}, ctr_q};
  assign diff_d  = (org_ext << 1) + {2'b00, prod_q} - (ctr_ext << 1);
  assign psum    = org_ext[PSumW-1:0] + {2'b00, prod_q[ProdW-1:1]};
  assign psum_top = psum[PSumW-1:PosW-1];

  always_comb begin
    if ((psum_top == '0) || (psum_top == '1)) begin
      pos_d = psum[PosW-1:0];
    end else if (psum[PSumW-1]) begin
      pos_d = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      pos_d = {1'b0, {(PosW-1){1'b1}}};
    end
  end

  // stage 3: magnitude
  assign mag_d = diff_q[DiffW-1] ? (~diff_q + DiffW'(1)) : diff_q;

  // stage 4: partial products of the square
  assign lo   = mag_q[LoW-1:0];
  assign hi   = mag_q[DiffW-1:LoW];
  assign ll_d = (2*LoW)'(lo) * (2*LoW)'(lo);
  assign hl_d = (HiW+LoW)'(hi) * (HiW+LoW)'(lo);
  assign hh_d = (2*HiW)'(hi) * (2*HiW)'(hi);

  // stage 5: square
  assign sq_d = {hh_q, {(2*LoW){1'b0}}} + SqW'({hl_q, {(LoW+1){1'b0}}}) + SqW'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= prod_d;
      ctr_q  <= center_i;
    end
    if (en_i[2]) begin
      diff_q <= diff_d;
      pos2_q <= pos_d;
    end
    if (en_i[3]) begin
      mag_q  <= mag_d;
      pos3_q <= pos2_q;
    end
    if (en_i[4]) begin
      ll_q   <= ll_d;
      hl_q   <= hl_d;
      hh_q   <= hh_d;
      pos4_q <= pos3_q;
    end
    if (en_i[5]) begin
      sq_q   <= sq_d;
      pos5_q <= pos4_q;
    end
  end

  assign pos_o = pos5_q;
  assign sq_o  = sq_q;

endmodule

[hw/rtl/svs_index.sv]
// ----------------------------------------------------------------------------
// svs_index
// linear voxel index x + dim_x*(y + dim_y*z), two multiply stages
// ----------------------------------------------------------------------------
module svs_index (
  input  logic                          clk_i,
  input  svs_pkg::svs_stage_en_t        en_i,
  input  logic [svs_pkg::DimW-1:0]      dim_x_i,
  input  logic [svs_pkg::DimW-1:0]      dim_y_i,
  input  logic [svs_pkg::CoordW-1:0]    voxel_x_i,
  input  logic [svs_pkg::CoordW-1:0]    voxel_y_i,
  input  logic [svs_pkg::CoordW-1:0]    voxel_z_i,
  output logic [svs_pkg::IdxW-1:0]      index_o
);

  localparam int unsigned DimW   = svs_pkg::DimW;
  localparam int unsigned CoordW = svs_pkg::CoordW;
  localparam int unsigned IdxW   = svs_pkg::IdxW;
  localparam int unsigned RowW   = DimW + CoordW + 1;
  localparam int unsigned FullW  = RowW + DimW + 1;

  logic [RowW-1:0]   row_d, row_q;
  logic [CoordW-1:0] vx_q;
  logic [FullW-1:0]  full;
  logic [IdxW-1:0]   idx2_q, idx3_q, idx4_q, idx5_q;

  assign row_d = RowW'(dim_y_i) * RowW'(voxel_z_i) + RowW'(voxel_y_i);
  assign full  = FullW'(row_q) * FullW'(dim_x_i) + FullW'(vx_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      row_q <= row_d;
      vx_q  <= voxel_x_i;
    end
    if (en_i[2]) idx2_q <= full[IdxW-1:0];
    if (en_i[3]) idx3_q <= idx2_q;
    if (en_i[4]) idx4_q <= idx3_q;
    if (en_i[5]) idx5_q <= idx4_q;
  end

  assign index_o = idx5_q;

endmodule

[hw/rtl/sphere_voxel_select.sv]
// ----------------------------------------------------------------------------
// sphere_voxel_select
// tests streamed voxels against a sphere query; unless the output stalls, one voxel per clock
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i/in_ready_o/in_data_i): one voxel with its sphere
//   query per transfer. out channel (out_valid_o/out_ready_i/out_data_o):
//   exactly one result per input transfer, in input order.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): register
//   writes, always ready; write only while no voxel is in flight. unknown
//   indexes are dropped.
// pipeline: seven register stages from input transfer to result valid (input
//   register, cell multiply, offset add, magnitude, partial products, square,
//   compare).
// throughput: 1 voxel per cycle while the output is not stalled.
// stall: each stage has a valid bit and loads when it is empty or its
//   successor moves, so bubbles collapse and the input keeps accepting while a
//   result waits, until all 7 stages are full.
// reset: empties the pipeline and loads origin 0, cell size 1.0 on every axis
//   and dimensions 256 along x and y.
// ----------------------------------------------------------------------------
module sphere_voxel_select (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  svs_pkg::svs_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output svs_pkg::svs_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [svs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [svs_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned NumStages = svs_pkg::NumStages;
  localparam int unsigned PosW      = svs_pkg::PosW;
  localparam int unsigned CellW     = svs_pkg::CellW;
  localparam int unsigned DimW      = svs_pkg::DimW;
  localparam int unsigned R2W       = svs_pkg::R2W;
  localparam int unsigned SqW       = svs_pkg::SqW;
  localparam int unsigned SumSqW    = svs_pkg::SumSqW;
  localparam int unsigned CmpW      = 32;

  // configuration registers
  logic signed [PosW-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic [CellW-1:0]       cell_x_q, cell_y_q, cell_z_q;
  logic [DimW-1:0]        dim_x_q, dim_y_q;

  // pipeline control
  logic [NumStages-1:0]   valid_d, valid_q;
  svs_pkg::svs_stage_en_t en;

  // payload
  svs_pkg::svs_in_t       in_q;
  logic                   ok_d;
  logic [R2W-1:0]         r2_d;
  logic                   ok_q [1:NumStages-2];
  logic [R2W-1:0]         r2_q [1:NumStages-2];
  logic signed [PosW-1:0] pos_x, pos_y, pos_z;
  logic [SqW-1:0]         sq_x, sq_y, sq_z;
  logic [svs_pkg::IdxW-1:0] index;
  logic [SumSqW-1:0]      dist2;
  svs_pkg::svs_out_t      out_d, out_q;

  svs_pkg::svs_axis_cfg_t cfg_ax, cfg_ay, cfg_az;

  // config writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      cell_x_q   <= CellW'(65536);
      cell_y_q   <= CellW'(65536);
      cell_z_q   <= CellW'(65536);
      dim_x_q    <= DimW'(256);
      dim_y_q    <= DimW'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        svs_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        svs_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        svs_pkg::CFG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        svs_pkg::CFG_CELL_X:   cell_x_q   <= cfg_data_i[CellW-1:0];
        svs_pkg::CFG_CELL_Y:   cell_y_q   <= cfg_data_i[CellW-1:0];
        svs_pkg::CFG_CELL_Z:   cell_z_q   <= cfg_data_i[CellW-1:0];
        svs_pkg::CFG_DIM_X:    dim_x_q    <= cfg_data_i[DimW-1:0];
        svs_pkg::CFG_DIM_Y:    dim_y_q    <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // stage k loads when empty or when stage k+1 can take its item
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // stage 1: qualifiers and radius squared
  assign ok_d = in_q.solid && (in_q.radius != '0) &&
                (cell_x_q != '0) && (cell_y_q != '0) && (cell_z_q != '0) &&
                ({1'b0, in_q.voxel_x} < dim_x_q) &&
                ({1'b0, in_q.voxel_y} < dim_y_q) &&
                (CmpW'(in_q.voxel_z) < CmpW'(svs_pkg::MaxDim));
  assign r2_d = R2W'(in_q.radius) * R2W'(in_q.radius);

  always_ff @(posedge clk_i) begin
    if (en[0]) in_q <= in_data_i;
    if (en[1]) begin
      ok_q[1] <= ok_d;
      r2_q[1] <= r2_d;
    end
    for (int k = 2; k <= NumStages - 2; k++) begin
      if (en[k]) begin
        ok_q[k] <= ok_q[k-1];
        r2_q[k] <= r2_q[k-1];
      end
    end
    if (en[NumStages-1]) out_q <= out_d;
  end

  // per-axis datapaths
  assign cfg_ax = '{origin: origin_x_q, cell_size: cell_x_q};
  assign cfg_ay = '{origin: origin_y_q, cell_size: cell_y_q};
  assign cfg_az = '{origin: origin_z_q, cell_size: cell_z_q};

  svs_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg_ax),
    .coord_i  (in_q.voxel_x),
    .center_i (in_q.center_x),
    .pos_o    (pos_x),
    .sq_o     (sq_x)
  );

  svs_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg_ay),
    .coord_i  (in_q.voxel_y),
    .center_i (in_q.center_y),
    .pos_o    (pos_y),
    .sq_o     (sq_y)
  );

  svs_axis u_axis_z (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg_az),
    .coord_i  (in_q.voxel_z),
    .center_i (in_q.center_z),
    .pos_o    (pos_z),
    .sq_o     (sq_z)
  );

  svs_index u_index (
    .clk_i     (clk_i),
    .en_i      (en),
    .dim_x_i   (dim_x_q),
    .dim_y_i   (dim_y_q),
    .voxel_x_i (in_q.voxel_x),
    .voxel_y_i (in_q.voxel_y),
    .voxel_z_i (in_q.voxel_z),
    .index_o   (index)
  );

  // last stage: squared distance (times four) against four radius squared
  assign dist2 = SumSqW'(sq_x) + SumSqW'(sq_y) + SumSqW'(sq_z);

  always_comb begin
    out_d.selected    = ok_q[NumStages-2] &&
                        (dist2 <= SumSqW'({r2_q[NumStages-2], 2'b00}));
    out_d.pos_x       = pos_x;
    out_d.pos_y       = pos_y;
    out_d.pos_z       = pos_z;
    out_d.voxel_index = index;
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/svs_checker.sv]
// ----------------------------------------------------------------------------
// svs_checker
// port-level checks of the sphere voxel select pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input svs_pkg::svs_out_t out_data_i
);

  localparam int unsigned OccW = $clog2(svs_pkg::NumStages + 1) + 1;

  logic            in_xfer, out_xfer;
  logic [OccW-1:0] occ_d, occ_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;
  assign occ_d    = occ_q + OccW'(in_xfer) - OccW'(out_xfer);

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled result changed")
  `ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, occ_q > OccW'(svs_pkg::NumStages), "more items in flight than stages")
  `ASSERT_NEVER(a_no_phantom, clk_i, rst_ni, out_valid_i && (occ_q == '0), "result with no item in flight")
  `ASSERT_PROP(a_ready_when_drained, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input blocked with empty output")

endmodule

bind sphere_voxel_select svs_checker u_svs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[dv/svs_select_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_select_checker
// watches the voxel, result and register channels of the sphere voxel select
// block, predicts every result from its own copy of the registers and
// compares each result transfer with the oldest prediction
// ----------------------------------------------------------------------------
module svs_select_checker
  import svs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  svs_in_t             in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  svs_out_t            out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  fails_o
);

  localparam logic signed [63:0] PosMax = 64'sd2147483647;
  localparam logic signed [63:0] PosMin = -64'sd2147483648;

  // register copy
  logic signed [PosW-1:0] org_x, org_y, org_z;
  logic [CellW-1:0]       cell_x, cell_y, cell_z;
  logic [DimW-1:0]        dim_x, dim_y;

  svs_out_t selections_q[$];
  svs_out_t want;
  int       fail_count = 0;

  assign fails_o = fail_count;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // twice the exact offset of the voxel center from the sphere center;
  // pos gets the floored, saturated center
  function automatic logic signed [63:0] axis_offset(
    input  logic signed [PosW-1:0] org,
    input  logic [CellW-1:0]       cell_size,
    input  logic [CoordW-1:0]      coord,
    input  logic signed [PosW-1:0] ctr,
    output logic signed [PosW-1:0] pos
  );
    logic signed [63:0] span, org_w, ctr_w, mid;
    span  = $signed({23'd0, coord, 1'b1} * {33'd0, cell_size});
    org_w = org;
    ctr_w = ctr;
    mid   = org_w + (span >>> 1);
    if (mid > PosMax) begin
      pos = 32'sh7fff_ffff;
    end else if (mid < PosMin) begin
      pos = 32'sh8000_0000;
    end else begin
      pos = mid[PosW-1:0];
    end
    return 2 * org_w + span - 2 * ctr_w;
  endfunction

  function automatic logic [127:0] square_mag(input logic signed [63:0] d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic svs_out_t select_voxel(input svs_in_t v);
    svs_out_t           r;
    logic signed [63:0] dx, dy, dz;
    logic signed [PosW-1:0] px, py, pz;
    logic [127:0]       dist2, reach2;
    logic [63:0]        lin;
    logic               in_grid, usable;
    dx = axis_offset(org_x, cell_x, v.voxel_x, v.center_x, px);
    dy = axis_offset(org_y, cell_y, v.voxel_y, v.center_y, py);
    dz = axis_offset(org_z, cell_z, v.voxel_z, v.center_z, pz);
    dist2  = square_mag(dx) + square_mag(dy) + square_mag(dz);
    reach2 = ({97'd0, v.radius} * {97'd0, v.radius}) << 2;
    in_grid = ({1'b0, v.voxel_x} < dim_x) && ({1'b0, v.voxel_y} < dim_y) &&
              (32'(v.voxel_z) < MaxDim);
    usable  = v.solid && (v.radius != '0) &&
              (cell_x != '0) && (cell_y != '0) && (cell_z != '0);
    lin = 64'(v.voxel_x) + 64'(dim_x) * (64'(v.voxel_y) + 64'(dim_y) * 64'(v.voxel_z));
    r.selected    = usable && in_grid && (dist2 <= reach2);
    r.pos_x       = px;
    r.pos_y       = py;
    r.pos_z       = pz;
    r.voxel_index = lin[IdxW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x  = '0;
      org_y  = '0;
      org_z  = '0;
      cell_x = 31'd65536;
      cell_y = 31'd65536;
      cell_z = 31'd65536;
      dim_x  = 9'd256;
      dim_y  = 9'd256;
      selections_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ORIGIN_X: org_x  = cfg_data_i;
          CFG_ORIGIN_Y: org_y  = cfg_data_i;
          CFG_ORIGIN_Z: org_z  = cfg_data_i;
          CFG_CELL_X:   cell_x = cfg_data_i[CellW-1:0];
          CFG_CELL_Y:   cell_y = cfg_data_i[CellW-1:0];
          CFG_CELL_Z:   cell_z = cfg_data_i[CellW-1:0];
          CFG_DIM_X:    dim_x  = cfg_data_i[DimW-1:0];
          CFG_DIM_Y:    dim_y  = cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
      // retire before predicting so a stray result never meets a fresh entry
      if (out_valid_i && out_ready_i) begin
        if (selections_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %h", out_data_i));
        end else begin
          want = selections_q.pop_front();
          if (out_data_i.selected != want.selected)
            report_mismatch($sformatf("selected got %b want %b",
                                      out_data_i.selected, want.selected));
          if (out_data_i.pos_x != want.pos_x)
            report_mismatch($sformatf("pos_x got %h want %h", out_data_i.pos_x, want.pos_x));
          if (out_data_i.pos_y != want.pos_y)
            report_mismatch($sformatf("pos_y got %h want %h", out_data_i.pos_y, want.pos_y));
          if (out_data_i.pos_z != want.pos_z)
            report_mismatch($sformatf("pos_z got %h want %h", out_data_i.pos_z, want.pos_z));
          if (out_data_i.voxel_index != want.voxel_index)
            report_mismatch($sformatf("voxel_index got %h want %h",
                                      out_data_i.voxel_index, want.voxel_index));
        end
      end
      if (in_valid_i && in_ready_i) selections_q.push_back(select_voxel(in_data_i));
      pending_o <= selections_q.size();
    end
  end

endmodule

[dv/sphere_voxel_select_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_voxel_select_test
// drives voxels with sphere queries into the block under several register
// settings and idle patterns; a checker beside the block predicts and
// compares every result, this module makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module sphere_voxel_select_test;
  import svs_pkg::*;

  localparam int LimitNs    = 5_000_000;
  localparam int NumPhases  = 16;
  localparam int PhaseItems = 115;

  // first register index that the block does not decode
  localparam logic [CfgIdxW-1:0] FirstSpareIdx = CfgIdxW'(CFG_DIM_Y) + CfgIdxW'(1);

  localparam logic signed [PosW-1:0] PosTop    = 32'sh7fff_ffff;
  localparam logic signed [PosW-1:0] PosBottom = 32'sh8000_0000;
  localparam logic [CellW-1:0]       CellOne   = 31'd65536;
  localparam logic [CellW-1:0]       CellTop   = '1;
  localparam logic [RadW-1:0]        RadTop    = '1;
  localparam logic [DimW-1:0]        DimFull   = 9'd256;
  localparam logic [DimW-1:0]        DimTop    = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block channels, all known from time zero
  logic                in_valid  = 1'b0;
  logic                in_ready;
  svs_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  svs_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int outstanding;
  int fails;
  int idle_pct  = 0;
  int stall_pct = 0;

  // register values as last written, used only to pick voxels and aim the sphere queries
  logic signed [PosW-1:0] sh_org  [3] = '{default: '0};
  logic [CellW-1:0]       sh_cell [3] = '{default: CellOne};
  logic [DimW-1:0]        sh_dim  [2] = '{default: DimFull};

  always #6 clk = ~clk;

  sphere_voxel_select u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  svs_select_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (outstanding),
    .fails_o     (fails)
  );

  // receiver: a fresh stall decision every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #(LimitNs);
    $display("TB_ERROR");
    $finish;
  end

  // one register write; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register load; upper bits above the field widths are random and
  // must be dropped by the block, plus one write to an undecoded index
  task automatic load_config(
    input logic signed [PosW-1:0] ox, oy, oz,
    input logic [CellW-1:0]       cx, cy, cz,
    input logic [DimW-1:0]        dx, dy
  );
    write_reg(FirstSpareIdx + CfgIdxW'($urandom_range(7, 0)), $urandom);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_CELL_X, {1'($urandom), cx});
    write_reg(CFG_CELL_Y, {1'($urandom), cy});
    write_reg(CFG_CELL_Z, {1'($urandom), cz});
    write_reg(CFG_DIM_X, {23'($urandom), dx});
    write_reg(CFG_DIM_Y, {23'($urandom), dy});
    cfg_valid <= 1'b0;
    sh_org[0]  = ox;
    sh_org[1]  = oy;
    sh_org[2]  = oz;
    sh_cell[0] = cx;
    sh_cell[1] = cy;
    sh_cell[2] = cz;
    sh_dim[0]  = dx;
    sh_dim[1]  = dy;
  endtask

  // stop sending and wait until every voxel in flight has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one voxel transfer, preceded by a random idle gap with junk on the bus
  task automatic send_voxel(input svs_in_t item);
    logic [159:0] junk;
    if ($urandom_range(99, 0) < idle_pct) begin
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_data  <= junk[$bits(svs_in_t)-1:0];
      do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [PosW-1:0] clip_pos(input longint v);
    if (v > 64'sd2147483647) return PosTop;
    if (v < -64'sd2147483648) return PosBottom;
    return 32'(v);
  endfunction

  // approximate voxel center on one axis under the current registers
  function automatic longint voxel_mid(input int ax, input logic [CoordW-1:0] c);
    return longint'(sh_org[ax]) + (longint'({c, 1'b1}) * longint'(sh_cell[ax])) / 2;
  endfunction

  function automatic svs_in_t mk_voxel(
    input logic [CoordW-1:0]      x, y, z,
    input logic                   solid,
    input logic signed [PosW-1:0] cx, cy, cz,
    input logic [RadW-1:0]        rad
  );
    svs_in_t v;
    v.voxel_x  = x;
    v.voxel_y  = y;
    v.voxel_z  = z;
    v.solid    = solid;
    v.center_x = cx;
    v.center_y = cy;
    v.center_z = cz;
    v.radius   = rad;
    return v;
  endfunction

  // mostly inside the grid, sometimes anywhere
  function automatic logic [CoordW-1:0] pick_coord(input logic [DimW-1:0] dim);
    if (dim == '0 || $urandom_range(4, 0) == 0) return CoordW'($urandom);
    return CoordW'($urandom_range((dim > DimFull) ? 32'd255 : 32'(dim) - 1, 0));
  endfunction

  function automatic longint spread(input logic [RadW-1:0] reach);
    longint off;
    off = longint'($urandom_range(reach, 0));
    return $urandom_range(1, 0) ? -off : off;
  endfunction

  function automatic logic signed [PosW-1:0] corner_pos();
    case ($urandom_range(3, 0))
      0:       return PosTop;
      1:       return PosBottom;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic svs_in_t gen_voxel();
    svs_in_t         v;
    int              mode, e;
    logic [RadW-1:0] reach;
    longint          off;
    v.voxel_x = pick_coord(sh_dim[0]);
    v.voxel_y = pick_coord(sh_dim[1]);
    v.voxel_z = $urandom_range(1, 0) ? CoordW'($urandom) : CoordW'($urandom_range(15, 0));
    v.solid   = ($urandom_range(9, 0) != 0);
    mode = $urandom_range(99, 0);
    if (mode < 65) begin
      // sphere around the voxel center, roughly half of them reach it
      e     = $urandom_range(30, 0);
      reach = RadW'((32'd1 << e) | ($urandom & ((32'd1 << e) - 1)));
      v.radius   = reach;
      v.center_x = clip_pos(voxel_mid(0, v.voxel_x) + spread(reach));
      v.center_y = clip_pos(voxel_mid(1, v.voxel_y) + spread(reach));
      v.center_z = clip_pos(voxel_mid(2, v.voxel_z) + spread(reach));
    end else if (mode < 80) begin
      v.center_x = $urandom;
      v.center_y = $urandom;
      v.center_z = $urandom;
      v.radius   = RadW'($urandom);
    end else if (mode < 90) begin
      v.center_x = corner_pos();
      v.center_y = corner_pos();
      v.center_z = corner_pos();
      case ($urandom_range(2, 0))
        0:       v.radius = '0;
        1:       v.radius = RadW'(1);
        default: v.radius = RadTop;
      endcase
    end else begin
      // voxel center right at the sphere surface, give or take one lsb
      reach = RadW'($urandom_range(32'd1 << 20, 1));
      off   = longint'(reach) + longint'($urandom_range(2, 0)) - 1;
      if ($urandom_range(1, 0)) off = -off;
      v.radius   = reach;
      v.center_x = clip_pos(voxel_mid(0, v.voxel_x) + off);
      v.center_y = clip_pos(voxel_mid(1, v.voxel_y));
      v.center_z = clip_pos(voxel_mid(2, v.voxel_z));
    end
    return v;
  endfunction

  initial begin
    logic signed [PosW-1:0] org_v  [3];
    logic [CellW-1:0]       cell_v [3];
    logic [DimW-1:0]        dim_v  [2];
    int                     kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, registers at their reset values -------------------------
    // empty voxel with everything zero
    send_voxel(mk_voxel(0, 0, 0, 1'b0, 0, 0, 0, 0));
    // sphere centered on the voxel, smallest radius
    send_voxel(mk_voxel(0, 0, 0, 1'b1, clip_pos(voxel_mid(0, 0)), clip_pos(voxel_mid(1, 0)),
                        clip_pos(voxel_mid(2, 0)), 1));
    // same with zero radius
    send_voxel(mk_voxel(0, 0, 0, 1'b1, clip_pos(voxel_mid(0, 0)), clip_pos(voxel_mid(1, 0)),
                        clip_pos(voxel_mid(2, 0)), 0));
    // far corner of the grid
    send_voxel(mk_voxel(255, 255, 255, 1'b1, clip_pos(voxel_mid(0, 255)),
                        clip_pos(voxel_mid(1, 255)), clip_pos(voxel_mid(2, 255)), CellOne));
    // extreme centers with the largest radius
    send_voxel(mk_voxel(255, 255, 255, 1'b1, PosBottom, PosBottom, PosBottom, RadTop));
    send_voxel(mk_voxel(0, 0, 0, 1'b1, PosTop, PosTop, PosTop, RadTop));
    // distance exactly the radius, then one lsb short, then not solid
    send_voxel(mk_voxel(1, 2, 3, 1'b1, clip_pos(voxel_mid(0, 1) - 65536),
                        clip_pos(voxel_mid(1, 2)), clip_pos(voxel_mid(2, 3)), CellOne));
    send_voxel(mk_voxel(1, 2, 3, 1'b1, clip_pos(voxel_mid(0, 1) - 65536),
                        clip_pos(voxel_mid(1, 2)), clip_pos(voxel_mid(2, 3)), CellOne - 1));
    send_voxel(mk_voxel(1, 2, 3, 1'b0, clip_pos(voxel_mid(0, 1) - 65536),
                        clip_pos(voxel_mid(1, 2)), clip_pos(voxel_mid(2, 3)), CellOne));

    // odd cell size leaves half an lsb on the center; narrow grid along x
    drain();
    load_config(-1, 5, 0, 31'd3, CellOne, CellOne, 9'd4, DimFull);
    send_voxel(mk_voxel(3, 0, 0, 1'b1, clip_pos(voxel_mid(0, 3)), clip_pos(voxel_mid(1, 0)),
                        clip_pos(voxel_mid(2, 0)), 2));
    send_voxel(mk_voxel(4, 0, 0, 1'b1, clip_pos(voxel_mid(0, 4)), clip_pos(voxel_mid(1, 0)),
                        clip_pos(voxel_mid(2, 0)), CellOne));
    send_voxel(mk_voxel(0, 255, 0, 1'b1, clip_pos(voxel_mid(0, 0)),
                        clip_pos(voxel_mid(1, 255)), clip_pos(voxel_mid(2, 0)), CellOne));

    // centers saturate high, index wraps, zero cell size along z
    drain();
    load_config(PosTop, PosTop, PosTop, CellTop, CellTop, '0, DimTop, DimTop);
    send_voxel(mk_voxel(255, 255, 255, 1'b1, PosTop, PosTop, PosTop, RadTop));
    send_voxel(mk_voxel(0, 0, 0, 1'b1, PosTop, PosTop, PosTop, RadTop));

    // origin at the bottom, no rows along y
    drain();
    load_config(PosBottom, PosBottom, PosBottom, CellTop, CellTop, CellTop, DimFull, '0);
    send_voxel(mk_voxel(0, 0, 0, 1'b1, PosBottom, PosBottom, PosBottom, RadTop));
    send_voxel(mk_voxel(255, 0, 7, 1'b1, PosTop, PosBottom, 0, RadTop));

    // single voxel grid with one-lsb cells
    drain();
    load_config(0, 0, 0, 31'd1, 31'd1, 31'd1, 9'd1, 9'd1);
    send_voxel(mk_voxel(0, 0, 0, 1'b1, 0, 0, 0, 1));
    send_voxel(mk_voxel(0, 1, 0, 1'b1, 0, 0, 0, 1));
    send_voxel(mk_voxel(0, 0, 255, 1'b1, 0, 0, 0, 1));

    // --- random phases ------------------------------------------------------
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      kind = phase % 8;
      for (int a = 0; a < 3; a++) begin
        org_v[a]  = '0;
        cell_v[a] = CellOne;
      end
      dim_v[0] = DimFull;
      dim_v[1] = DimFull;
      case (kind)
        0: begin
          // near-default grid, shifted origin
          for (int a = 0; a < 3; a++) org_v[a] = PosW'($signed(24'($urandom)));
        end
        1: begin
          for (int a = 0; a < 3; a++) begin
            org_v[a]  = PosW'($signed(28'($urandom)));
            cell_v[a] = CellW'($urandom_range(32'd1 << 20, 1));
          end
          dim_v[0] = DimW'($urandom_range(256, 1));
          dim_v[1] = DimW'($urandom_range(256, 1));
        end
        2: begin
          // everything at the top: saturated centers, wrapping index
          for (int a = 0; a < 3; a++) begin
            org_v[a]  = PosTop;
            cell_v[a] = CellTop;
          end
          dim_v[0] = DimTop;
          dim_v[1] = DimTop;
        end
        3: begin
          for (int a = 0; a < 3; a++) begin
            org_v[a]  = PosBottom;
            cell_v[a] = CellTop;
          end
        end
        4: begin
          // one axis with zero cell size, dimensions possibly zero
          cell_v[$urandom_range(2, 0)] = '0;
          dim_v[0] = DimW'($urandom_range(300, 0));
          dim_v[1] = DimW'($urandom_range(300, 0));
        end
        5: begin
          // tiny cells and a small grid, many coordinates fall outside
          for (int a = 0; a < 3; a++) begin
            org_v[a]  = '1;
            cell_v[a] = CellW'($urandom_range(15, 1));
          end
          dim_v[0] = DimW'($urandom_range(8, 1));
          dim_v[1] = DimW'($urandom_range(8, 1));
        end
        6: begin
          for (int a = 0; a < 3; a++) begin
            org_v[a]  = $urandom;
            cell_v[a] = CellW'($urandom);
          end
          dim_v[0] = DimW'($urandom);
          dim_v[1] = DimW'($urandom);
        end
        default: begin
          for (int a = 0; a < 3; a++) cell_v[a] = 31'd1;
          dim_v[0] = 9'd1;
          dim_v[1] = 9'd1;
        end
      endcase
      load_config(org_v[0], org_v[1], org_v[2], cell_v[0], cell_v[1], cell_v[2],
                  dim_v[0], dim_v[1]);

      // idle pattern: none, sender only, receiver only, both
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 23;
          stall_pct = 23;
        end
      endcase

      for (int n = 0; n < PhaseItems; n++) begin
        // now and then hold the sender until the pipeline has emptied
        if (phase % 3 == 1 && n == PhaseItems / 2) drain();
        send_voxel(gen_voxel());
      end
    end

    // --- wind down ------------------------------------------------------------
    drain();
    repeat (NumStages + 4) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
